// ----- hw/rtl/ps2_mouse_cursor_tracker_unit_macros.svh -----
// assertion macros for the ps2 mouse cursor tracker
`ifndef PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PMCT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2 cursor tracker check failed");

// next-cycle implication, checked out of reset
`define PMCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2 cursor tracker check failed");

`endif

// ----- hw/rtl/ps2mct_pkg.sv -----
// types and constants shared by the ps2 mouse cursor tracker
package ps2mct_pkg;

    localparam logic [7:0]  ACK_BYTE    = 8'hFA;
    localparam logic [7:0]  HDR_OR      = 8'h37;
    localparam logic [7:0]  HDR_MATCH   = 8'h3F;
    localparam int          XSIGN_IDX   = 4;
    localparam int          YSIGN_IDX   = 5;
    localparam int          X_MARGIN    = 9;

    localparam int          CFG_W       = 13;
    localparam int          CURSOR_W    = 12;

    localparam logic [12:0] WIDTH_RST   = 13'd320;
    localparam logic [12:0] HEIGHT_RST  = 13'd200;
    localparam logic [11:0] START_X_RST = 12'd152;
    localparam logic [11:0] START_Y_RST = 12'd78;

    localparam logic [1:0]  REG_WIDTH   = 2'd0;
    localparam logic [1:0]  REG_HEIGHT  = 2'd1;
    localparam logic [1:0]  REG_START_X = 2'd2;
    localparam logic [1:0]  REG_START_Y = 2'd3;

    localparam logic [1:0]  PCODE_ACK    = 2'd0;
    localparam logic [1:0]  PCODE_HEADER = 2'd1;
    localparam logic [1:0]  PCODE_X      = 2'd2;
    localparam logic [1:0]  PCODE_Y      = 2'd3;

    typedef enum logic [3:0] {
        PH_ACK    = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_X      = 4'b0100,
        PH_Y      = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       done;
        logic [2:0] buttons;
        logic [8:0] dx;
        logic [9:0] dy;
        logic [1:0] phase_code;
    } pkt_t;

endpackage

// ----- hw/rtl/ps2mct_decode.sv -----
// packet framing: ack wait, header sync, movement byte collection
module ps2mct_decode
    import ps2mct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output pkt_t       pkt
);

    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_reg, x_next;
    logic [2:0] buttons_reg, buttons_next;
    logic [8:0] dy_raw;

    always_comb
    begin
        phase_next   = phase_reg;
        header_next  = header_reg;
        x_next       = x_reg;
        buttons_next = buttons_reg;
        dy_raw       = {header_reg[YSIGN_IDX], rx_byte};
        pkt.done     = 1'b0;
        pkt.dx       = '0;
        pkt.dy       = '0;
        case (phase_reg)
            PH_ACK:
            begin
                if (rx_byte == ACK_BYTE)
                    phase_next = PH_HEADER;
            end
            PH_HEADER:
            begin
                if ((rx_byte | HDR_OR) == HDR_MATCH)
                begin
                    header_next = rx_byte;
                    phase_next  = PH_X;
                end
            end
            PH_X:
            begin
                x_next     = rx_byte;
                phase_next = PH_Y;
            end
            PH_Y:
            begin
                phase_next   = PH_HEADER;
                buttons_next = header_reg[2:0];
                pkt.done     = 1'b1;
                pkt.dx       = {header_reg[XSIGN_IDX], x_reg};
                pkt.dy       = 10'd0 - {dy_raw[8], dy_raw};
            end
            default:
            begin
                phase_next = PH_ACK;
            end
        endcase
        pkt.buttons = buttons_next;
        case (phase_next)
            PH_ACK:    pkt.phase_code = PCODE_ACK;
            PH_HEADER: pkt.phase_code = PCODE_HEADER;
            PH_X:      pkt.phase_code = PCODE_X;
            PH_Y:      pkt.phase_code = PCODE_Y;
            default:   pkt.phase_code = PCODE_ACK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_ACK;
            header_reg  <= '0;
            x_reg       <= '0;
            buttons_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            header_reg  <= header_next;
            x_reg       <= x_next;
            buttons_reg <= buttons_next;
        end
    end

endmodule

// ----- hw/rtl/ps2mct_cursor.sv -----
// cursor position, screen limits and clamping
module ps2mct_cursor
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  pkt_t                  pkt,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic [COORD_BITS-1:0] pos_x,
    output logic [COORD_BITS-1:0] pos_y
);

    localparam int SW = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;
    localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'(START_X_RST);
    localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'(START_Y_RST);
    localparam logic [SW-1:0] COORD_MAX_EXT =
        {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic [9:0]            dx_ext;
    logic [9:0]            half_x;
    logic [9:0]            half_y;
    logic [SW-1:0]         lim_x;
    logic [SW-1:0]         lim_y;

    function automatic logic [COORD_BITS-1:0] clamp_move(
        input logic [COORD_BITS-1:0] pos,
        input logic [9:0]            half,
        input logic [SW-1:0]         lim
    );
        logic [SW-1:0] sum;
        logic [SW-1:0] hi;
        logic [SW-1:0] res;
        sum = {{(SW-COORD_BITS){1'b0}}, pos} + {{(SW-10){half[9]}}, half};
        if (lim[SW-1])
            hi = '0;
        else if (lim > COORD_MAX_EXT)
            hi = COORD_MAX_EXT;
        else
            hi = lim;
        if (sum[SW-1])
            res = '0;
        else if (sum > hi)
            res = hi;
        else
            res = sum;
        return res[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        // halving rounds toward zero
        dx_ext = {pkt.dx[8], pkt.dx};
        half_x = 10'($signed(dx_ext + {9'd0, dx_ext[9]}) >>> 1);
        half_y = 10'($signed(pkt.dy + {9'd0, pkt.dy[9]}) >>> 1);
        lim_x  = {{(SW-CFG_W){1'b0}}, width_reg} - SW'(X_MARGIN);
        lim_y  = {{(SW-CFG_W){1'b0}}, height_reg} - SW'(1);
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (pkt.done)
        begin
            pos_x_next = clamp_move(pos_x_reg, half_x, lim_x);
            pos_y_next = clamp_move(pos_y_reg, half_y, lim_y);
        end
    end

    assign pos_x = pos_x_next;
    assign pos_y = pos_y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            pos_x_reg  <= POS_X_RST;
            pos_y_reg  <= POS_Y_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WIDTH:   width_reg  <= cfg_data;
                REG_HEIGHT:  height_reg <= cfg_data;
                REG_START_X: pos_x_reg  <= COORD_BITS'(cfg_data[CURSOR_W-1:0]);
                REG_START_Y: pos_y_reg  <= COORD_BITS'(cfg_data[CURSOR_W-1:0]);
                default:     width_reg  <= width_reg;
            endcase
        end
        else if (step)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

endmodule

// ----- hw/rtl/ps2_mouse_cursor_tracker_unit.sv -----
// top level of the ps2 mouse cursor tracker
// usage:
//   in channel (in_valid/in_ready, rx_byte) takes one mouse byte per transaction
//   out channel (out_valid/out_ready) gives one result per byte: packet_done,
//   buttons, delta_x, delta_y, cursor_x, cursor_y, decode_phase
//   config port: cfg_wr_en with cfg_index 0 width, 1 height, 2 start x, 3 start y;
//   writing a start register also moves the cursor there
// path: an input transaction reaches the result through the input register and
//   the result register
// throughput: one byte per cycle while out_ready holds; decode and clamp sit in
//   one pass between the two registers
// reset: waits for the acknowledge byte, cursor at 152,78, screen 320x200
// stall: a held result keeps the result register full; the input register
//   still takes one more byte, then in_ready drops until out_ready returns
module ps2_mouse_cursor_tracker_unit
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              rx_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    packet_done,
    output logic [2:0]              buttons,
    output logic signed [8:0]       delta_x,
    output logic signed [9:0]       delta_y,
    output logic [CURSOR_W-1:0]     cursor_x,
    output logic [CURSOR_W-1:0]     cursor_y,
    output logic [1:0]              decode_phase,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

`include "ps2_mouse_cursor_tracker_unit_macros.svh"

    logic                     s1_valid_reg, s1_valid_next;
    logic [7:0]               s1_byte_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     packet_done_reg;
    logic [2:0]               buttons_reg;
    logic [8:0]               delta_x_reg;
    logic [9:0]               delta_y_reg;
    logic [CURSOR_W-1:0]      cursor_x_reg;
    logic [CURSOR_W-1:0]      cursor_y_reg;
    logic [1:0]               phase_reg;
    logic                     step;
    logic                     in_fire;
    pkt_t                     pkt;
    logic [COORD_BITS-1:0]    pos_x;
    logic [COORD_BITS-1:0]    pos_y;
    logic [COORD_BITS+CURSOR_W-1:0] pos_x_ext;
    logic [COORD_BITS+CURSOR_W-1:0] pos_y_ext;

    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && !out_ready);

    ps2mct_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (s1_byte_reg),
        .pkt     (pkt)
    );

    ps2mct_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pkt       (pkt),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

    assign pos_x_ext = {{CURSOR_W{1'b0}}, pos_x};
    assign pos_y_ext = {{CURSOR_W{1'b0}}, pos_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_byte_reg <= rx_byte;
        if (step)
        begin
            packet_done_reg <= pkt.done;
            buttons_reg     <= pkt.buttons;
            delta_x_reg     <= pkt.dx;
            delta_y_reg     <= pkt.dy;
            cursor_x_reg    <= pos_x_ext[CURSOR_W-1:0];
            cursor_y_reg    <= pos_y_ext[CURSOR_W-1:0];
            phase_reg       <= pkt.phase_code;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packet_done  = packet_done_reg;
    assign buttons      = buttons_reg;
    assign delta_x      = $signed(delta_x_reg);
    assign delta_y      = $signed(delta_y_reg);
    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign decode_phase = phase_reg;

    `PMCT_ASSERT_IMPL(a_done_resyncs, out_valid_reg && packet_done_reg, phase_reg == PCODE_HEADER)
    `PMCT_ASSERT_IMPL(a_idle_no_delta, out_valid_reg && !packet_done_reg, delta_x_reg == '0 && delta_y_reg == '0)
    `PMCT_ASSERT_IMPL(a_backpressure, !in_ready, s1_valid_reg && out_valid_reg && !out_ready)
    `PMCT_ASSERT_NEXT(a_input_lands, in_fire, s1_valid_reg)

endmodule

// ----- tb/cursor_tracker_checker.sv -----
`timescale 1ns / 1ps
// checker for the ps2 mouse cursor tracker: predicts each result and compares it
module cursor_tracker_checker
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                packet_done,
    input  logic [2:0]          buttons,
    input  logic signed [8:0]   delta_x,
    input  logic signed [9:0]   delta_y,
    input  logic [CURSOR_W-1:0] cursor_x,
    input  logic [CURSOR_W-1:0] cursor_y,
    input  logic [1:0]          decode_phase,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  fail_count,
    output int                  pending
);

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    typedef struct packed {
        logic                done;
        logic [2:0]          btn;
        logic [8:0]          dx;
        logic [9:0]          dy;
        logic [CURSOR_W-1:0] cx;
        logic [CURSOR_W-1:0] cy;
        logic [1:0]          phase;
    } cursor_report_t;

    cursor_report_t expected_reports[$];
    cursor_report_t want;
    cursor_report_t got;

    logic [CFG_W-1:0] width_q;
    logic [CFG_W-1:0] height_q;
    logic [1:0]       phase_q;
    logic [7:0]       header_q;
    logic [7:0]       xbyte_q;
    logic [2:0]       btn_q;
    int               pos_x;
    int               pos_y;
    int               move_x;
    int               move_y;
    int               errors = 0;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // upper limit saturates to the coordinate range before clamping
    function automatic int clamp_coord(input int v, input int lim);
        int hi;
        hi = (lim < 0) ? 0 : ((lim > COORD_MAX) ? COORD_MAX : lim);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_q  = WIDTH_RST;
            height_q = HEIGHT_RST;
            phase_q  = PCODE_ACK;
            header_q = '0;
            xbyte_q  = '0;
            btn_q    = '0;
            pos_x    = int'(START_X_RST) & COORD_MAX;
            pos_y    = int'(START_Y_RST) & COORD_MAX;
            expected_reports.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_WIDTH:   width_q = cfg_data;
                    REG_HEIGHT:  height_q = cfg_data;
                    REG_START_X: pos_x = int'(cfg_data[11:0]) & COORD_MAX;
                    REG_START_Y: pos_y = int'(cfg_data[11:0]) & COORD_MAX;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got = '{packet_done, buttons, delta_x, delta_y, cursor_x, cursor_y,
                        decode_phase};
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result at %0t: done=%0d btn=%0d x=%0d y=%0d",
                                 $realtime, got.done, got.btn, got.cx, got.cy);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.done !== want.done || got.btn !== want.btn ||
                        got.dx !== want.dx || got.dy !== want.dy ||
                        got.cx !== want.cx || got.cy !== want.cy ||
                        got.phase !== want.phase)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch at %0t", $realtime);
                            $display("  exp done=%0d btn=%0d dx=%0d dy=%0d x=%0d y=%0d ph=%0d",
                                     want.done, want.btn, $signed(want.dx),
                                     $signed(want.dy), want.cx, want.cy, want.phase);
                            $display("  got done=%0d btn=%0d dx=%0d dy=%0d x=%0d y=%0d ph=%0d",
                                     got.done, got.btn, $signed(got.dx),
                                     $signed(got.dy), got.cx, got.cy, got.phase);
                        end
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                move_x = 0;
                move_y = 0;
                want.done = 1'b0;
                case (phase_q)
                    PCODE_ACK:
                    begin
                        if (rx_byte == ACK_BYTE)
                            phase_q = PCODE_HEADER;
                    end
                    PCODE_HEADER:
                    begin
                        if ((rx_byte | HDR_OR) == HDR_MATCH)
                        begin
                            header_q = rx_byte;
                            phase_q  = PCODE_X;
                        end
                    end
                    PCODE_X:
                    begin
                        xbyte_q = rx_byte;
                        phase_q = PCODE_Y;
                    end
                    default:
                    begin
                        phase_q   = PCODE_HEADER;
                        want.done = 1'b1;
                        btn_q     = header_q[2:0];
                        move_x = int'(xbyte_q) - (header_q[XSIGN_IDX] ? 256 : 0);
                        move_y = -(int'(rx_byte) - (header_q[YSIGN_IDX] ? 256 : 0));
                        pos_x = clamp_coord(pos_x + move_x / 2, int'(width_q) - X_MARGIN);
                        pos_y = clamp_coord(pos_y + move_y / 2, int'(height_q) - 1);
                    end
                endcase
                want.btn   = btn_q;
                want.dx    = move_x[8:0];
                want.dy    = move_y[9:0];
                want.cx    = pos_x[CURSOR_W-1:0];
                want.cy    = pos_y[CURSOR_W-1:0];
                want.phase = phase_q;
                expected_reports.push_back(want);
            end
        end
        pending    <= expected_reports.size();
        fail_count <= errors;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench top for the ps2 mouse cursor tracker: stimulus, clocking and verdict
module tb;
    import ps2mct_pkg::*;

    localparam int LIMIT = 1000000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          rx_byte;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                packet_done;
    logic [2:0]          buttons;
    logic signed [8:0]   delta_x;
    logic signed [9:0]   delta_y;
    logic [CURSOR_W-1:0] cursor_x;
    logic [CURSOR_W-1:0] cursor_y;
    logic [1:0]          decode_phase;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                no_idle = 1'b0;
    int                  fail_count;
    int                  pending;
    int                  cycles = 0;
    int                  ready_hold = 0;
    int                  ready_pick;

    ps2_mouse_cursor_tracker_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_done  (packet_done),
        .buttons      (buttons),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .decode_phase (decode_phase),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cursor_tracker_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_done  (packet_done),
        .buttons      (buttons),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .decode_phase (decode_phase),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls: mostly short, a few long
    always @(posedge clk)
    begin
        if (no_idle)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 60)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 15);
            end
            else if (ready_pick < 94)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** ps2_mouse_cursor_tracker_unit: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // bias 1 prefers the sign bit set, 2 prefers it clear, 0 is even
    function automatic logic pick_sign(input int bias);
        if (bias == 0)
            return 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 80)
            return (bias == 1);
        return (bias != 1);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] bx,
                               input logic [7:0] by);
        send_byte(hdr);
        send_byte(bx);
        send_byte(by);
    endtask

    // wait for every transaction to drain before touching the registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_bytes(input int count, input int xbias, input int ybias);
        int sent;
        logic [7:0] hdr;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                hdr = {2'b00, pick_sign(ybias), pick_sign(xbias), 1'b1,
                       3'($urandom_range(0, 7))};
                send_packet(hdr, 8'($urandom), 8'($urandom));
                sent += 3;
            end
            else
            begin
                send_byte(8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_WIDTH;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before the acknowledge are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h08);
        send_byte(ACK_BYTE);
        // bad headers, then packets with valid headers
        send_byte(ACK_BYTE);
        send_byte(8'h48);
        send_byte(8'h07);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h3F, 8'h00, 8'h00);
        send_packet(8'h0F, 8'hFF, 8'hFF);
        send_packet(8'h1A, 8'h01, 8'h01);
        send_packet(8'h29, ACK_BYTE, 8'hFF);
        random_bytes(195, 0, 0);

        settle();
        configure(13'd16, 13'd1, 13'd0, 13'd0);
        random_bytes(195, 2, 2);

        settle();
        configure(13'd4096, 13'd4096, 13'd4095, 13'd4095);
        random_bytes(195, 2, 1);

        settle();
        configure(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        random_bytes(195, 2, 1);

        // width below nine and height zero
        settle();
        configure(13'd0, 13'd0, 13'd100, 13'd100);
        random_bytes(195, 0, 0);

        settle();
        configure(13'd9, 13'd2, 13'h1000, 13'd1);
        random_bytes(195, 0, 0);

        settle();
        configure(13'($urandom_range(16, 4096)), 13'($urandom_range(1, 4096)),
                  13'($urandom_range(0, 4095)), 13'($urandom_range(0, 4095)));
        random_bytes(195, 1, 2);

        settle();
        configure(WIDTH_RST, HEIGHT_RST, 13'(START_X_RST), 13'(START_Y_RST));
        no_idle <= 1'b1;
        random_bytes(195, 0, 0);

        settle();
        no_idle <= 1'b0;
        configure(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
        random_bytes(195, 0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** ps2_mouse_cursor_tracker_unit: PASSED **");
        else
            $display("** ps2_mouse_cursor_tracker_unit: FAILED **");
        $finish;
    end

endmodule
